### hdl/fbpa_pkg.sv
// Shared types and constants of the frame buffer pool allocator.
package fbpa_pkg;

	localparam int MAX_ENTRIES = 8;
	localparam int ID_BITS     = 16;
	localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_INIT = 2'd0,
		OP_GET  = 2'd1,
		OP_PUT  = 2'd2,
		OP_MARK = 2'd3
	} op_t;

	localparam logic [1:0] USE_FREE = 2'd0;
	localparam logic [1:0] USE_CUR  = 2'd1;
	localparam logic [1:0] USE_PREP = 2'd2;

	typedef struct packed {
		logic [1:0]         use_st;
		logic               filled;
		logic [ID_BITS-1:0] id;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		op_t                op;
		logic [ID_BITS-1:0] id;
		logic               cur;
		logic [2:0]         idx;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic [2:0] index;
		logic       filled;
	} res_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
	} ram_req_t;

endpackage

### hdl/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/fbpa_ctrl.sv
// Sequencer of the pool: init sweep, get scan and read-modify-write of one entry.
module fbpa_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  fbpa_pkg::req_t          in_req,
	output logic                    busy,
	input  logic [3:0]              pool_entries,
	output fbpa_pkg::ram_req_t      ram_req,
	input  fbpa_pkg::entry_t        ram_rd,
	output logic                    res_vld,
	output fbpa_pkg::res_t          res,
	input  logic                    res_take
);
	import fbpa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_SCAN,
		ST_DECIDE,
		ST_RD,
		ST_WR,
		ST_FIN
	} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   live_q;
	logic               chk_vld_s1;
	logic [IDX_W-1:0]   chk_idx_s1;
	logic               same_q, blank_q, free_q;
	logic [IDX_W-1:0]   same_idx_q, blank_idx_q, free_idx_q;
	logic               same_fill_q;
	res_t               res_q;

	logic [CNT_W-1:0]   init_n;
	logic               idx_ok;
	logic               hit;
	logic [IDX_W-1:0]   hit_idx;
	logic               hit_fill;
	logic [1:0]         new_use;
	logic               ram_free;

	// saturate the pool size to 1..MAX_ENTRIES
	always_comb begin
		if (pool_entries == 4'd0) begin
			init_n = CNT_W'(1);
		end else if (32'(pool_entries) > 32'(MAX_ENTRIES)) begin
			init_n = CNT_W'(MAX_ENTRIES);
		end else begin
			init_n = CNT_W'(pool_entries);
		end
	end

	assign idx_ok   = 32'(req_q.idx) < 32'(live_q);
	assign new_use  = req_q.cur ? USE_CUR : USE_PREP;
	assign ram_free = (ram_rd.use_st == USE_FREE);

	always_comb begin
		hit      = 1'b1;
		hit_idx  = '0;
		hit_fill = 1'b0;
		if (same_q) begin
			hit_idx  = same_idx_q;
			hit_fill = same_fill_q;
		end else if (blank_q) begin
			hit_idx = blank_idx_q;
		end else if (free_q) begin
			hit_idx = free_idx_q;
		end else if (!(req_q.cur && live_q != '0)) begin
			hit = 1'b0;
		end
	end

	always_comb begin
		ram_req         = '0;
		ram_req.rd_addr = cnt_q[IDX_W-1:0];
		ram_req.wr_addr = cnt_q[IDX_W-1:0];
		case (state_q)
			ST_CLR: begin
				ram_req.wr_en = 1'b1;
				if (cnt_q == live_q - CNT_W'(1) && live_q > CNT_W'(1)) begin
					ram_req.wr_data.use_st = USE_CUR;
				end
			end
			ST_SCAN: begin
				ram_req.rd_en = (cnt_q < live_q);
			end
			ST_DECIDE: begin
				ram_req.wr_en   = hit;
				ram_req.wr_addr = hit_idx;
				ram_req.wr_data = '{use_st: new_use, filled: hit_fill, id: req_q.id};
			end
			ST_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = IDX_W'(req_q.idx);
			end
			ST_WR: begin
				ram_req.wr_en   = 1'b1;
				ram_req.wr_addr = IDX_W'(req_q.idx);
				ram_req.wr_data = ram_rd;
				if (req_q.op == OP_PUT) begin
					ram_req.wr_data.use_st = USE_FREE;
					if (ram_rd.id == {ID_BITS{1'b1}}) begin
						ram_req.wr_data.filled = 1'b0;
					end
				end else begin
					ram_req.wr_data.filled = 1'b1;
				end
			end
			default: begin
				ram_req.rd_en = 1'b0;
			end
		endcase
	end

	assign busy    = (state_q != ST_IDLE);
	assign res_vld = (state_q == ST_FIN);
	assign res     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			live_q     <= '0;
			cnt_q      <= '0;
			chk_vld_s1 <= 1'b0;
			same_q     <= 1'b0;
			blank_q    <= 1'b0;
			free_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q   <= in_req;
						cnt_q   <= '0;
						res_q   <= '0;
						same_q  <= 1'b0;
						blank_q <= 1'b0;
						free_q  <= 1'b0;
						case (in_req.op)
							OP_INIT: begin
								live_q  <= init_n;
								state_q <= ST_CLR;
							end
							OP_GET:  state_q <= ST_SCAN;
							default: state_q <= ST_RD;
						endcase
					end
				end
				ST_CLR: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == live_q - CNT_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_SCAN: begin
					chk_vld_s1 <= (cnt_q < live_q);
					chk_idx_s1 <= cnt_q[IDX_W-1:0];
					if (cnt_q < live_q) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end else if (!chk_vld_s1) begin
						state_q <= ST_DECIDE;
					end
					// record the first entry of each preference class
					if (chk_vld_s1 && ram_free) begin
						if (!same_q && ram_rd.id == req_q.id) begin
							same_q      <= 1'b1;
							same_idx_q  <= chk_idx_s1;
							same_fill_q <= ram_rd.filled;
						end
						if (!blank_q && !ram_rd.filled) begin
							blank_q     <= 1'b1;
							blank_idx_q <= chk_idx_s1;
						end
						if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= chk_idx_s1;
						end
					end
				end
				ST_DECIDE: begin
					res_q   <= '{granted: hit, index: hit ? 3'(hit_idx) : 3'd0,
						filled: hit_fill};
					state_q <= ST_FIN;
				end
				ST_RD: begin
					state_q <= idx_ok ? ST_WR : ST_FIN;
				end
				ST_WR: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hdl/frame_buffer_pool_allocator_unit.sv
// Top level of the frame buffer pool allocator.
//
// Input channel (in_valid / in_stall): one item per request: opcode (init, get,
// put, mark filled), picture_id, for_current and entry_index. An item is taken
// at a clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): exactly one item per request:
// granted, granted_index and already_filled; all zero for anything but a
// successful get.
// Configuration: cfg_we / cfg_wdata write pool_entries (reset 8); write it
// only while the block is idle. Init saturates it to 1..8 entries.
// Steps after the accepting edge: get reads the live entries from the pool RAM,
// one entry a cycle, then drains the read, decides and writes back; put and
// mark read the entry and write it back (no write for an index outside the
// pool); init writes each live entry. The next item can be taken at the edge
// after out_valid rises while the output register is free; items are handled
// one at a time and in_stall is high while an item is in progress.
// Reset: the pool holds no live entries until the first init, so every get is
// refused. A stalled receiver holds the result in the output register; the
// block accepts the next item meanwhile and parks its result until the
// register frees.
module frame_buffer_pool_allocator_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [3:0]                   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   opcode,
	input  logic signed [15:0]           picture_id,
	input  logic                         for_current,
	input  logic [2:0]                   entry_index,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         granted,
	output logic [2:0]                   granted_index,
	output logic                         already_filled
);
	import fbpa_pkg::*;

	logic       [3:0] pool_entries_q;
	req_t             req;
	ram_req_t         ram_req;
	logic [ENTRY_W-1:0] ram_rd_bits;
	entry_t           ram_rd;
	logic             busy;
	logic             res_vld;
	res_t             res;
	logic             res_take;
	logic             out_valid_q;
	res_t             out_q;

	// hold the pool size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_entries_q <= 4'd8;
		end else if (cfg_we) begin
			pool_entries_q <= cfg_wdata;
		end
	end

	// picture id is sign-extended or cut to the stored id width
	assign req = '{op: op_t'(opcode), id: ID_BITS'(picture_id), cur: for_current,
		idx: entry_index};

	assign in_stall = busy;

	fbpa_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_ENTRIES)
	) u_pool_ram (
		.clk     (clk),
		.wr_en   (ram_req.wr_en),
		.wr_addr (ram_req.wr_addr),
		.wr_data (ram_req.wr_data),
		.rd_en   (ram_req.rd_en),
		.rd_addr (ram_req.rd_addr),
		.rd_data (ram_rd_bits)
	);

	assign ram_rd = entry_t'(ram_rd_bits);

	fbpa_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_req       (req),
		.busy         (busy),
		.pool_entries (pool_entries_q),
		.ram_req      (ram_req),
		.ram_rd       (ram_rd),
		.res_vld      (res_vld),
		.res          (res),
		.res_take     (res_take)
	);

	// take a finished result when the output register is empty or draining
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_vld) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign granted        = out_q.granted;
	assign granted_index  = out_q.index;
	assign already_filled = out_q.filled;

endmodule
